// File: design/sfpf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfpf_pkg
// shared types and constants for the sync frame parser with fletcher checksum
// ----------------------------------------------------------------------------
package sfpf_pkg;

    localparam int unsigned PAYLOAD_LEN = 5;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned IDX_W       = 3;
    localparam int unsigned STATUS_W    = 2;
    localparam int unsigned VALUE_W     = 2 * BYTE_W;
    localparam int unsigned APB_AW      = 3;
    localparam int unsigned APB_DW      = 32;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PAYLOAD_LEN - 1);

    localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'd181;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'd98;

    localparam logic REG_SYNC_FIRST  = 1'b0;
    localparam logic REG_SYNC_SECOND = 1'b1;

    localparam logic [STATUS_W-1:0] ST_GOOD  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_CHK_A = 2'd1;
    localparam logic [STATUS_W-1:0] ST_CHK_B = 2'd2;

    typedef enum logic [2:0] {
        PH_SYNC1   = 3'd0,
        PH_SYNC2   = 3'd1,
        PH_ID      = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_CHK_A   = 3'd4,
        PH_CHK_B   = 3'd5
    } t_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] sync_first;
        logic [BYTE_W-1:0] sync_second;
    } t_cfg;

endpackage
`default_nettype wire

// File: design/sfpf_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfpf channel interfaces
// valid/ready channels for received bytes and parsed frame results
// ----------------------------------------------------------------------------
interface sfpf_in_if;
    import sfpf_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfpf_out_if;
    import sfpf_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   message_id;
    logic [BYTE_W-1:0]   phase_a;
    logic [BYTE_W-1:0]   phase_b;
    logic [BYTE_W-1:0]   phase_c;
    logic [VALUE_W-1:0]  raw_value;

    modport source (
        output valid, output status, output message_id, output phase_a,
        output phase_b, output phase_c, output raw_value, input ready
    );
    modport sink (
        input valid, input status, input message_id, input phase_a,
        input phase_b, input phase_c, input raw_value, output ready
    );
endinterface
`default_nettype wire

// File: design/sfpf_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfpf_cfg_regs
// apb register file holding the two sync byte values
// ----------------------------------------------------------------------------
module sfpf_cfg_regs
    import sfpf_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;
    logic wr_en;

    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (paddr[2])
                REG_SYNC_FIRST:  n_cfg.sync_first  = pwdata[BYTE_W-1:0];
                REG_SYNC_SECOND: n_cfg.sync_second = pwdata[BYTE_W-1:0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_SYNC_FIRST:  prdata = {{(APB_DW-BYTE_W){1'b0}}, r_cfg.sync_first};
            REG_SYNC_SECOND: prdata = {{(APB_DW-BYTE_W){1'b0}}, r_cfg.sync_second};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_first  <= SYNC_FIRST_RST;
            r_cfg.sync_second <= SYNC_SECOND_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule
`default_nettype wire

// File: design/sfpf_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfpf_core
// input byte register, frame state machine with fletcher sums, result register
// ----------------------------------------------------------------------------
module sfpf_core
    import sfpf_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_cfg   i_cfg,
    sfpf_in_if.sink     i_rx,
    sfpf_out_if.source  o_res
);

    // input stage
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              adv;
    logic              in_ready;

    // parser state
    t_phase            r_phase;
    t_phase            n_phase;
    logic [IDX_W-1:0]  r_idx;
    logic [IDX_W-1:0]  n_idx;
    logic [BYTE_W-1:0] r_sum_a;
    logic [BYTE_W-1:0] n_sum_a;
    logic [BYTE_W-1:0] r_sum_b;
    logic [BYTE_W-1:0] n_sum_b;
    logic [BYTE_W-1:0] r_held_id;
    logic [BYTE_W-1:0] n_held_id;
    logic [BYTE_W-1:0] r_store [PAYLOAD_LEN];
    logic              store_we;

    // result stage
    logic                r_out_valid;
    logic                n_out_valid;
    logic                emit;
    logic [STATUS_W-1:0] emit_status;
    logic [STATUS_W-1:0] r_status;
    logic [BYTE_W-1:0]   r_msg_id;
    logic [BYTE_W-1:0]   r_ph_a;
    logic [BYTE_W-1:0]   r_ph_b;
    logic [BYTE_W-1:0]   r_ph_c;
    logic [VALUE_W-1:0]  r_raw;

    assign adv      = r_in_valid & (~r_out_valid | o_res.ready);
    assign in_ready = ~r_in_valid | adv;
    assign i_rx.ready = in_ready;

    assign o_res.valid      = r_out_valid;
    assign o_res.status     = r_status;
    assign o_res.message_id = r_msg_id;
    assign o_res.phase_a    = r_ph_a;
    assign o_res.phase_b    = r_ph_b;
    assign o_res.phase_c    = r_ph_c;
    assign o_res.raw_value  = r_raw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready & i_rx.valid) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_idx       = r_idx;
        n_sum_a     = r_sum_a;
        n_sum_b     = r_sum_b;
        n_held_id   = r_held_id;
        store_we    = 1'b0;
        emit        = 1'b0;
        emit_status = ST_GOOD;
        if (adv) begin
            case (r_phase)
                PH_SYNC1: begin
                    if (r_in_byte == i_cfg.sync_first) begin
                        n_phase = PH_SYNC2;
                        n_sum_a = '0;
                        n_sum_b = '0;
                    end
                end
                PH_SYNC2: begin
                    n_phase = (r_in_byte == i_cfg.sync_second) ? PH_ID : PH_SYNC1;
                end
                PH_ID: begin
                    n_held_id = r_in_byte;
                    n_idx     = '0;
                    n_phase   = PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    store_we = (r_idx <= LAST_IDX);
                    n_sum_a  = r_sum_a + r_in_byte;
                    n_sum_b  = r_sum_b + n_sum_a;
                    n_idx    = r_idx + 1'b1;
                    if (n_idx > LAST_IDX) begin
                        n_phase = PH_CHK_A;
                    end
                end
                PH_CHK_A: begin
                    if (r_in_byte == r_sum_a) begin
                        n_phase = PH_CHK_B;
                    end else begin
                        emit        = 1'b1;
                        emit_status = ST_CHK_A;
                        n_phase     = PH_SYNC1;
                    end
                end
                PH_CHK_B: begin
                    emit        = 1'b1;
                    emit_status = (r_in_byte == r_sum_b) ? ST_GOOD : ST_CHK_B;
                    n_phase     = PH_SYNC1;
                end
                default: begin
                    n_phase = PH_SYNC1;
                end
            endcase
        end
    end

    always_comb begin
        n_out_valid = r_out_valid & ~o_res.ready;
        if (emit) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SYNC1;
            r_idx       <= '0;
            r_sum_a     <= '0;
            r_sum_b     <= '0;
            r_held_id   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_idx       <= n_idx;
            r_sum_a     <= n_sum_a;
            r_sum_b     <= n_sum_b;
            r_held_id   <= n_held_id;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[r_idx] <= r_in_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_status <= emit_status;
            r_msg_id <= r_held_id;
            r_ph_a   <= r_store[0];
            r_ph_b   <= r_store[1];
            r_ph_c   <= r_store[2];
            r_raw    <= {r_store[4], r_store[3]};
        end
    end

    // a new result only comes out of one of the two checksum phases
    a_emit_from_chk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> (r_phase == PH_CHK_A || r_phase == PH_CHK_B))
        else $error("result raised outside checksum phases");

    // payload index stays inside the payload while collecting
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_idx <= LAST_IDX))
        else $error("payload index out of range");

    // first checksum phase is entered only after the payload
    a_chk_a_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_CHK_A && $past(r_phase) != PH_CHK_A)
            |-> ($past(r_phase) == PH_PAYLOAD && $past(r_idx) == LAST_IDX))
        else $error("checksum phase entered early");

    // held result is never overwritten before it is taken
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid & ~o_res.ready) |-> ~emit)
        else $error("result register overrun");

    // status code of a delivered result is one of the defined codes
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_status == ST_GOOD || r_status == ST_CHK_A ||
                         r_status == ST_CHK_B))
        else $error("undefined status code");

endmodule
`default_nettype wire

// File: design/sync_frame_parser_fletcher_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sync_frame_parser_fletcher_unit
// hunts sync bytes, collects id and payload, checks fletcher-8 sums
// ----------------------------------------------------------------------------
// flow: a byte is registered at its transfer and parsed once the result register
//   is free or being taken; a parsed checksum byte loads the result register
// throughput: one byte per cycle, limited only by the one-entry result register
// reset: synchronous active-low; parser returns to sync hunt, sums and id clear,
//   sync bytes return to 181 and 98; payload bytes are not reset
// ----------------------------------------------------------------------------
module sync_frame_parser_fletcher_unit
    import sfpf_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    sfpf_in_if.sink                i_rx,
    sfpf_out_if.source             o_res,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready
);

    t_cfg cfg;

    sfpf_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    sfpf_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_rx    (i_rx),
        .o_res   (o_res)
    );

endmodule
`default_nettype wire

// File: verif/sfpf_frame_checker.sv
// ----------------------------------------------------------------------------
// sfpf_frame_checker
// Watches the byte and result channels and the register port of the sync frame
// parser. Keeps its own copy of the parser state and sync bytes, predicts the
// frame result of every byte transfer and compares each result transfer with
// the oldest prediction.
// ----------------------------------------------------------------------------
module sfpf_frame_checker
    import sfpf_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    sfpf_in_if                     i_rx,
    sfpf_out_if                    i_res,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    input  wire logic              pready,
    output int                     o_fail_count,
    output int                     o_pending
);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BYTE_W-1:0]   message_id;
        logic [BYTE_W-1:0]   phase_a;
        logic [BYTE_W-1:0]   phase_b;
        logic [BYTE_W-1:0]   phase_c;
        logic [VALUE_W-1:0]  raw_value;
    } t_frame;

    t_cfg              cfg;
    t_phase            phase;
    logic [BYTE_W-1:0] payload [PAYLOAD_LEN];
    logic [IDX_W-1:0]  idx;
    logic [BYTE_W-1:0] sum_a;
    logic [BYTE_W-1:0] sum_b;
    logic [BYTE_W-1:0] held_id;
    t_frame            expected_frames [$];
    int                fail_count = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic t_frame frame_of(input logic [STATUS_W-1:0] status);
        t_frame f;
        f.status     = status;
        f.message_id = held_id;
        f.phase_a    = payload[0];
        f.phase_b    = payload[1];
        f.phase_c    = payload[2];
        f.raw_value  = {payload[4], payload[3]};
        return f;
    endfunction

    // advances the parser copy by one byte, returns 1 when a frame is reported
    function automatic bit parse_byte(input logic [BYTE_W-1:0] b, output t_frame f);
        bit hit;
        hit = 1'b0;
        f   = '0;
        case (phase)
            PH_SYNC1: begin
                if (b == cfg.sync_first) begin
                    phase = PH_SYNC2;
                    sum_a = '0;
                    sum_b = '0;
                end
            end
            PH_SYNC2: begin
                phase = (b == cfg.sync_second) ? PH_ID : PH_SYNC1;
            end
            PH_ID: begin
                held_id = b;
                idx     = '0;
                phase   = PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                if (idx < PAYLOAD_LEN) begin
                    payload[idx] = b;
                end
                sum_a = sum_a + b;
                sum_b = sum_b + sum_a;
                idx   = idx + 1'b1;
                if (idx >= PAYLOAD_LEN) begin
                    phase = PH_CHK_A;
                end
            end
            PH_CHK_A: begin
                if (b == sum_a) begin
                    phase = PH_CHK_B;
                end else begin
                    f     = frame_of(ST_CHK_A);
                    hit   = 1'b1;
                    phase = PH_SYNC1;
                end
            end
            PH_CHK_B: begin
                f     = frame_of((b == sum_b) ? ST_GOOD : ST_CHK_B);
                hit   = 1'b1;
                phase = PH_SYNC1;
            end
            default: begin
                phase = PH_SYNC1;
            end
        endcase
        return hit;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_frame got;
        t_frame want;
        t_frame pred;
        if (!i_rst_n) begin
            cfg.sync_first  = SYNC_FIRST_RST;
            cfg.sync_second = SYNC_SECOND_RST;
            phase           = PH_SYNC1;
            idx             = '0;
            sum_a           = '0;
            sum_b           = '0;
            held_id         = '0;
            for (int i = 0; i < PAYLOAD_LEN; i++) begin
                payload[i] = '0;
            end
            expected_frames.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                got.status     = i_res.status;
                got.message_id = i_res.message_id;
                got.phase_a    = i_res.phase_a;
                got.phase_b    = i_res.phase_b;
                got.phase_c    = i_res.phase_c;
                got.raw_value  = i_res.raw_value;
                if (expected_frames.size() == 0) begin
                    $error("result transfer with no frame expected: status %0d id %0d",
                           got.status, got.message_id);
                    fail_count++;
                end else begin
                    want = expected_frames.pop_front();
                    check_field("status", want.status, got.status);
                    check_field("message_id", want.message_id, got.message_id);
                    check_field("phase_a", want.phase_a, got.phase_a);
                    check_field("phase_b", want.phase_b, got.phase_b);
                    check_field("phase_c", want.phase_c, got.phase_c);
                    check_field("raw_value", want.raw_value, got.raw_value);
                end
            end
            if (psel && penable && pwrite && pready) begin
                if (paddr[APB_AW-1:2] == REG_SYNC_FIRST) begin
                    cfg.sync_first = pwdata[BYTE_W-1:0];
                end else if (paddr[APB_AW-1:2] == REG_SYNC_SECOND) begin
                    cfg.sync_second = pwdata[BYTE_W-1:0];
                end
            end
            if (i_rx.valid && i_rx.ready) begin
                if (parse_byte(i_rx.rx_byte, pred)) begin
                    expected_frames.push_back(pred);
                end
            end
        end
        o_pending    <= expected_frames.size();
        o_fail_count <= fail_count;
    end

endmodule

// File: verif/tb_sync_frame_parser_fletcher_unit.sv
// ----------------------------------------------------------------------------
// tb_sync_frame_parser_fletcher_unit
// Drives received bytes into the sync frame parser: a short directed part, then
// random well-formed frames mixed with broken frames and line noise, over four
// idle/stall phases with different sync bytes. A separate checker predicts and
// compares the results; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_sync_frame_parser_fletcher_unit;
    import sfpf_pkg::*;

    typedef enum {
        FR_GOOD,
        FR_BAD_A,
        FR_BAD_B,
        FR_BAD_SYNC,
        FR_NOISE
    } t_frame_kind;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    int                chk_fail_count;
    int                chk_pending;

    int unsigned       tx_idle_pct  = 0;
    int unsigned       rx_stall_pct = 0;
    int unsigned       rx_calm_left = 0;
    bit                tx_calm      = 1'b0;
    int unsigned       bytes_sent   = 0;
    logic [BYTE_W-1:0] cur_first;
    logic [BYTE_W-1:0] cur_second;

    sfpf_in_if  rx_if ();
    sfpf_out_if res_if ();

    sync_frame_parser_fletcher_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    sfpf_frame_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx         (rx_if),
        .i_res        (res_if),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .o_fail_count (chk_fail_count),
        .o_pending    (chk_pending)
    );

    always #5 i_clk = ~i_clk;

    // receiver stalls, with occasional calm stretches
    always @(negedge i_clk) begin
        if (rx_calm_left > 0) begin
            rx_calm_left  <= rx_calm_left - 1;
            res_if.ready  <= 1'b1;
        end else begin
            if ($urandom_range(99) < 2) begin
                rx_calm_left <= $urandom_range(40, 10);
            end
            res_if.ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic [BYTE_W-1:0] rand_byte();
        int unsigned r;
        r = $urandom_range(9);
        if (r == 0) begin
            return '0;
        end else if (r == 1) begin
            return '1;
        end
        return BYTE_W'($urandom_range(255));
    endfunction

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while (!tx_calm && $urandom_range(99) < tx_idle_pct) begin
            rx_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        @(posedge i_clk);
        while (!rx_if.ready) begin
            @(posedge i_clk);
        end
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        rx_if.valid <= 1'b0;
        @(negedge i_clk);
        while (chk_pending != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic apb_write(input logic idx, input logic [BYTE_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= APB_DW'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic send_frame(input t_frame_kind kind, input logic [BYTE_W-1:0] id,
                              input logic [PAYLOAD_LEN-1:0][BYTE_W-1:0] pl);
        logic [BYTE_W-1:0] ca;
        logic [BYTE_W-1:0] cb;
        logic [BYTE_W-1:0] bad;
        ca = '0;
        cb = '0;
        for (int i = 0; i < PAYLOAD_LEN; i++) begin
            ca = ca + pl[i];
            cb = cb + ca;
        end
        case (kind)
            FR_NOISE: begin
                repeat ($urandom_range(4, 1)) send_byte(BYTE_W'($urandom_range(255)));
            end
            FR_BAD_SYNC: begin
                if (cur_first != cur_second && $urandom_range(1) == 1) begin
                    bad = cur_first;
                end else begin
                    bad = cur_second ^ BYTE_W'($urandom_range(255, 1));
                end
                send_byte(cur_first);
                send_byte(bad);
            end
            default: begin
                send_byte(cur_first);
                send_byte(cur_second);
                send_byte(id);
                for (int i = 0; i < PAYLOAD_LEN; i++) begin
                    send_byte(pl[i]);
                end
                if (kind == FR_BAD_A) begin
                    send_byte(ca ^ BYTE_W'($urandom_range(255, 1)));
                end else begin
                    send_byte(ca);
                    send_byte((kind == FR_BAD_B) ? (cb ^ BYTE_W'($urandom_range(255, 1))) : cb);
                end
            end
        endcase
    endtask

    task automatic random_frame();
        logic [PAYLOAD_LEN-1:0][BYTE_W-1:0] pl;
        logic [BYTE_W-1:0]                  id;
        int unsigned                        pick;
        pick = $urandom_range(99);
        id   = rand_byte();
        for (int i = 0; i < PAYLOAD_LEN; i++) begin
            pl[i] = rand_byte();
        end
        tx_calm = ($urandom_range(99) < 15);
        if (pick < 60) begin
            send_frame(FR_GOOD, id, pl);
        end else if (pick < 70) begin
            send_frame(FR_BAD_A, id, pl);
        end else if (pick < 80) begin
            send_frame(FR_BAD_B, id, pl);
        end else if (pick < 88) begin
            send_frame(FR_BAD_SYNC, id, pl);
        end else begin
            send_frame(FR_NOISE, id, pl);
        end
    endtask

    initial begin
        logic [BYTE_W-1:0] first_tbl [4];
        logic [BYTE_W-1:0] second_tbl [4];
        int unsigned       tx_tbl [4];
        int unsigned       rx_tbl [4];
        int unsigned       quota;
        bit                paused;
        first_tbl  = '{SYNC_FIRST_RST, 8'h00, 8'hFF, 8'h5A};
        second_tbl = '{SYNC_SECOND_RST, 8'hFF, 8'h00, 8'h5A};
        tx_tbl     = '{0, 45, 0, 23};
        rx_tbl     = '{0, 0, 45, 23};

        i_rst_n        = 1'b0;
        rx_if.valid    = 1'b0;
        rx_if.rx_byte  = '0;
        res_if.ready   = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        cur_first      = SYNC_FIRST_RST;
        cur_second     = SYNC_SECOND_RST;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: extremes, first checksum failure, bad second sync byte
        send_frame(FR_GOOD, 8'h00, {PAYLOAD_LEN{8'hFF}});
        send_frame(FR_BAD_A, 8'hFF, {PAYLOAD_LEN{8'h00}});
        send_byte(cur_first);
        send_byte(cur_first);
        send_byte(8'h00);
        send_byte(8'hFF);

        for (int ph = 0; ph < 4; ph++) begin
            if (ph > 0) begin
                wait_idle();
                apb_write(REG_SYNC_FIRST, first_tbl[ph]);
                apb_write(REG_SYNC_SECOND, second_tbl[ph]);
                cur_first  = first_tbl[ph];
                cur_second = second_tbl[ph];
            end
            tx_idle_pct  = tx_tbl[ph];
            rx_stall_pct = rx_tbl[ph];
            quota        = bytes_sent + 260;
            paused       = 1'b0;
            while (bytes_sent < quota) begin
                // drain everything once mid-phase
                if (!paused && bytes_sent + 130 > quota) begin
                    wait_idle();
                    paused = 1'b1;
                end
                random_frame();
            end
        end
        rx_if.valid <= 1'b0;

        while (chk_pending != 0) begin
            @(negedge i_clk);
        end
        repeat (8) @(negedge i_clk);
        if (chk_fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
